// ===== rtl/efr_pkg.sv =====
// efr_pkg: shared types, codes and constants of the escaped frame receiver
// no dependencies; imported by efr_core, escaped_frame_receiver and tb_top
package efr_pkg;

  localparam logic [7:0] ESC_XOR  = 8'h20;
  localparam logic [7:0] SUM_GOOD = 8'hFF;
  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FAILED  = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_BREAK   = 2'd3;

  localparam logic [1:0] ACK_NONE   = 2'd0;
  localparam logic [1:0] ACK_OK     = 2'd1;
  localparam logic [1:0] ACK_FAILED = 2'd2;

  localparam logic [2:0] REG_OPEN_BYTE     = 3'd0;
  localparam logic [2:0] REG_ESCAPE_BYTE   = 3'd1;
  localparam logic [2:0] REG_EXPECTED_TYPE = 3'd2;
  localparam logic [2:0] REG_DATA_TYPE     = 3'd3;
  localparam logic [2:0] REG_ACK_TYPE      = 3'd4;
  localparam logic [2:0] REG_BREAK_CODE    = 3'd5;
  localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd6;

  localparam logic [7:0]  RST_OPEN_BYTE     = 8'h7E;
  localparam logic [7:0]  RST_ESCAPE_BYTE   = 8'h7D;
  localparam logic [7:0]  RST_EXPECTED_TYPE = 8'd1;
  localparam logic [7:0]  RST_DATA_TYPE     = 8'd1;
  localparam logic [7:0]  RST_ACK_TYPE      = 8'd2;
  localparam logic [7:0]  RST_BREAK_CODE    = 8'd3;
  localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd1000;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_LEN   = 3'd1,
    PH_TYPE  = 3'd2,
    PH_BODY  = 3'd3,
    PH_CKSUM = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0]  open_byte;
    logic [7:0]  escape_byte;
    logic [7:0]  expected_type;
    logic [7:0]  data_type;
    logic [7:0]  ack_type;
    logic [7:0]  break_code;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic       more_pending;
  } item_t;

  typedef struct packed {
    logic       res_kind;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic [1:0] status;
    logic [1:0] ack_request;
    logic [7:0] ack_value;
    logic       break_active;
    logic [7:0] body_length;
  } result_t;

endpackage

// ===== rtl/efr_core.sv =====
// efr_core: frame parser state and per-item next-state logic
// depends on efr_pkg; instantiated by escaped_frame_receiver
module efr_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  efr_pkg::cfg_t    cfg,
  input  efr_pkg::item_t   item,
  output logic             res_valid,
  output efr_pkg::result_t res
);
  import efr_pkg::*;

  phase_t      phase, phase_next;
  logic        escape_pending, escape_pending_next;
  logic [7:0]  frame_len, frame_len_next;
  logic [7:0]  body_count, body_count_next;
  logic [7:0]  frame_type, frame_type_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  last_ack, last_ack_next;
  logic        break_flag, break_flag_next;
  logic [15:0] tick_count, tick_count_next;

  logic [15:0] tick_inc;
  logic [7:0]  b;
  logic [7:0]  sum_b;
  logic [7:0]  count_inc;
  logic        kind;
  logic [7:0]  pay;
  logic [7:0]  idx;
  logic [1:0]  st;
  logic [1:0]  ack;
  logic        emit;

  always_comb begin
    tick_inc  = (tick_count == TICK_MAX) ? tick_count : tick_count + 16'd1;
    b         = escape_pending ? (item.rx_byte ^ ESC_XOR) : item.rx_byte;
    sum_b     = running_sum + b;
    count_inc = body_count + 8'd1;

    phase_next          = phase;
    escape_pending_next = escape_pending;
    frame_len_next      = frame_len;
    body_count_next     = body_count;
    frame_type_next     = frame_type;
    running_sum_next    = running_sum;
    last_ack_next       = last_ack;
    break_flag_next     = break_flag;
    tick_count_next     = tick_count;
    emit = 1'b0;
    kind = KIND_END;
    pay  = 8'd0;
    idx  = 8'd0;
    st   = ST_OK;
    ack  = ACK_NONE;

    if (item.func == FUNC_TICK) begin
      tick_count_next = tick_inc;
      if (tick_inc >= cfg.timeout_ticks) begin
        phase_next          = PH_HUNT;
        escape_pending_next = 1'b0;
        tick_count_next     = 16'd0;
        emit = 1'b1;
        st   = ST_TIMEOUT;
      end
    end else if (phase == PH_HUNT) begin
      if (item.rx_byte == cfg.open_byte) begin
        phase_next          = PH_LEN;
        escape_pending_next = 1'b0;
      end
    end else if (!escape_pending && item.rx_byte == cfg.escape_byte) begin
      escape_pending_next = 1'b1;
    end else begin
      escape_pending_next = 1'b0;
      case (phase)
        PH_LEN: begin
          frame_len_next = b;
          phase_next     = PH_TYPE;
        end
        PH_TYPE: begin
          frame_type_next  = b;
          running_sum_next = b;
          body_count_next  = 8'd0;
          phase_next       = (frame_len == 8'd0) ? PH_CKSUM : PH_BODY;
        end
        PH_BODY: begin
          running_sum_next = sum_b;
          body_count_next  = count_inc;
          if (count_inc >= frame_len) begin
            phase_next = PH_CKSUM;
          end
          if (frame_type == cfg.data_type) begin
            emit = 1'b1;
            kind = KIND_PAYLOAD;
            pay  = b;
            idx  = body_count;
          end else begin
            last_ack_next = b;
          end
        end
        PH_CKSUM: begin
          running_sum_next = sum_b;
          phase_next       = PH_HUNT;
          if (frame_type != cfg.expected_type) begin
            emit = 1'b0;
          end else if (frame_type == cfg.ack_type && last_ack == cfg.break_code) begin
            break_flag_next = 1'b1;
            tick_count_next = 16'd0;
            emit = 1'b1;
            st   = ST_BREAK;
          end else if (cfg.expected_type == cfg.data_type && item.more_pending) begin
            emit = 1'b0;
          end else begin
            tick_count_next = 16'd0;
            emit = 1'b1;
            st   = (sum_b == SUM_GOOD) ? ST_OK : ST_FAILED;
            if (frame_type == cfg.data_type) begin
              break_flag_next = 1'b0;
              ack = (sum_b == SUM_GOOD) ? ACK_OK : ACK_FAILED;
            end
          end
        end
        default: begin
          phase_next      = PH_HUNT;
          tick_count_next = 16'd0;
        end
      endcase
    end

    res_valid        = en && emit;
    res.res_kind     = kind;
    res.payload_byte = pay;
    res.byte_index   = idx;
    res.status       = st;
    res.ack_request  = ack;
    res.ack_value    = last_ack_next;
    res.break_active = break_flag_next;
    res.body_length  = frame_len_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      escape_pending <= 1'b0;
      frame_len      <= 8'd0;
      body_count     <= 8'd0;
      frame_type     <= 8'd0;
      running_sum    <= 8'd0;
      last_ack       <= 8'd0;
      break_flag     <= 1'b0;
      tick_count     <= 16'd0;
    end else if (en) begin
      phase          <= phase_next;
      escape_pending <= escape_pending_next;
      frame_len      <= frame_len_next;
      body_count     <= body_count_next;
      frame_type     <= frame_type_next;
      running_sum    <= running_sum_next;
      last_ack       <= last_ack_next;
      break_flag     <= break_flag_next;
      tick_count     <= tick_count_next;
    end
  end

  a_end_clears_ticks: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.res_kind == KIND_END |=> tick_count == 16'd0 && phase == PH_HUNT)
    else $error("end of read did not restart the read");

  a_hunt_no_escape: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HUNT |-> !escape_pending)
    else $error("escape pending while hunting");

endmodule

// ===== rtl/escaped_frame_receiver.sv =====
// escaped_frame_receiver: top level with config registers, input and result registers
// depends on efr_pkg and efr_core
//
//   channel  signals                               direction
//   in       in_valid in_ready func rx_byte more_pending   request in
//   out      out_valid out_ready res_kind .. body_length  request out
//   cfg      cfg_we cfg_index cfg_data              write only
//
// one request per cycle sustained while results are taken; each request waits in the input
// register, the parser state updates as it leaves that register and the result is registered;
// a held request waits only while the result register is full and not taken
// synchronous active-high reset: parser idle hunting, config back to defaults
module escaped_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [7:0]  rx_byte,
  input  logic        more_pending,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        res_kind,
  output logic [7:0]  payload_byte,
  output logic [7:0]  byte_index,
  output logic [1:0]  status,
  output logic [1:0]  ack_request,
  output logic [7:0]  ack_value,
  output logic        break_active,
  output logic [7:0]  body_length,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import efr_pkg::*;

  cfg_t    cfg;
  item_t   hold;
  logic    hold_valid;
  logic    process;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign process  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_byte     <= RST_OPEN_BYTE;
      cfg.escape_byte   <= RST_ESCAPE_BYTE;
      cfg.expected_type <= RST_EXPECTED_TYPE;
      cfg.data_type     <= RST_DATA_TYPE;
      cfg.ack_type      <= RST_ACK_TYPE;
      cfg.break_code    <= RST_BREAK_CODE;
      cfg.timeout_ticks <= RST_TIMEOUT_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OPEN_BYTE:     cfg.open_byte     <= cfg_data[7:0];
        REG_ESCAPE_BYTE:   cfg.escape_byte   <= cfg_data[7:0];
        REG_EXPECTED_TYPE: cfg.expected_type <= cfg_data[7:0];
        REG_DATA_TYPE:     cfg.data_type     <= cfg_data[7:0];
        REG_ACK_TYPE:      cfg.ack_type      <= cfg_data[7:0];
        REG_BREAK_CODE:    cfg.break_code    <= cfg_data[7:0];
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold.func         <= func;
      hold.rx_byte      <= rx_byte;
      hold.more_pending <= more_pending;
    end
  end

  efr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .en        (process),
    .cfg       (cfg),
    .item      (hold),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign res_kind     = out_res.res_kind;
  assign payload_byte = out_res.payload_byte;
  assign byte_index   = out_res.byte_index;
  assign status       = out_res.status;
  assign ack_request  = out_res.ack_request;
  assign ack_value    = out_res.ack_value;
  assign break_active = out_res.break_active;
  assign body_length  = out_res.body_length;

  a_payload_no_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_kind == KIND_PAYLOAD |-> status == ST_OK && ack_request == ACK_NONE)
    else $error("payload result carries status or ack");

  a_break_flag_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_kind == KIND_END && status == ST_BREAK |-> break_active)
    else $error("break result without break flag");

  a_held_not_lost: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !process |=> hold_valid && $stable(hold))
    else $error("held request dropped before processing");

  a_ack_only_on_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && ack_request != ACK_NONE |-> res_kind == KIND_END &&
      (status == ST_OK || status == ST_FAILED))
    else $error("ack request with wrong status");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking testbench for escaped_frame_receiver, random and directed frames
// holds a scoreboard class with its own model of the frame parser
// depends on efr_pkg and the escaped_frame_receiver rtl
module tb_top;
  import efr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  class frame_board;
    cfg_t regs;
    phase_t ph;
    bit esc_pend;
    bit brk;
    logic [7:0] len;
    logic [7:0] cnt;
    logic [7:0] ftype;
    logic [7:0] sum;
    logic [7:0] last_ack;
    logic [15:0] ticks;
    result_t pending_results[$];
    int errors;
    int checked;
    int payloads;
    int ends;
    int status_seen[4];

    function new();
      regs = '{RST_OPEN_BYTE, RST_ESCAPE_BYTE, RST_EXPECTED_TYPE, RST_DATA_TYPE,
               RST_ACK_TYPE, RST_BREAK_CODE, RST_TIMEOUT_TICKS};
      len = '0;
      cnt = '0;
      ftype = '0;
      sum = '0;
      last_ack = '0;
      brk = 1'b0;
      restart_read();
    endfunction

    function void restart_read();
      ph = PH_HUNT;
      esc_pend = 1'b0;
      ticks = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] d);
      case (idx)
        REG_OPEN_BYTE:     regs.open_byte = d[7:0];
        REG_ESCAPE_BYTE:   regs.escape_byte = d[7:0];
        REG_EXPECTED_TYPE: regs.expected_type = d[7:0];
        REG_DATA_TYPE:     regs.data_type = d[7:0];
        REG_ACK_TYPE:      regs.ack_type = d[7:0];
        REG_BREAK_CODE:    regs.break_code = d[7:0];
        REG_TIMEOUT_TICKS: regs.timeout_ticks = d;
        default: ;
      endcase
    endfunction

    // advance the parser by one accepted request, queue any result it causes
    function void note_request(logic f, logic [7:0] raw, logic more);
      logic [7:0] b;
      result_t r;
      bit emit;
      bit good;
      bit is_data;
      r = '0;
      emit = 1'b0;
      if (f == FUNC_TICK) begin
        if (ticks != TICK_MAX) ticks++;
        if (ticks >= regs.timeout_ticks) begin
          restart_read();
          emit = 1'b1;
          r.res_kind = KIND_END;
          r.status = ST_TIMEOUT;
        end
      end else if (ph == PH_HUNT) begin
        if (raw == regs.open_byte) begin
          ph = PH_LEN;
          esc_pend = 1'b0;
        end
      end else if (!esc_pend && raw == regs.escape_byte) begin
        esc_pend = 1'b1;
      end else begin
        b = esc_pend ? (raw ^ ESC_XOR) : raw;
        esc_pend = 1'b0;
        case (ph)
          PH_LEN: begin
            len = b;
            ph = PH_TYPE;
          end
          PH_TYPE: begin
            ftype = b;
            sum = b;
            cnt = '0;
            ph = (len == 8'd0) ? PH_CKSUM : PH_BODY;
          end
          PH_BODY: begin
            r.byte_index = cnt;
            sum = sum + b;
            cnt = cnt + 8'd1;
            if (cnt >= len) ph = PH_CKSUM;
            if (ftype == regs.data_type) begin
              emit = 1'b1;
              r.res_kind = KIND_PAYLOAD;
              r.payload_byte = b;
            end else begin
              last_ack = b;
            end
          end
          default: begin
            sum = sum + b;
            ph = PH_HUNT;
            if (ftype == regs.expected_type) begin
              if (ftype == regs.ack_type && last_ack == regs.break_code) begin
                brk = 1'b1;
                restart_read();
                emit = 1'b1;
                r.res_kind = KIND_END;
                r.status = ST_BREAK;
              end else if (!(regs.expected_type == regs.data_type && more)) begin
                is_data = (ftype == regs.data_type);
                if (is_data) brk = 1'b0;
                good = (sum == SUM_GOOD);
                restart_read();
                emit = 1'b1;
                r.res_kind = KIND_END;
                r.status = good ? ST_OK : ST_FAILED;
                r.ack_request = !is_data ? ACK_NONE : (good ? ACK_OK : ACK_FAILED);
              end
            end
          end
        endcase
      end
      if (emit) begin
        r.ack_value = last_ack;
        r.break_active = brk;
        r.body_length = len;
        pending_results.push_back(r);
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("tb_top: mismatch: %s", msg);
    endtask

    task compare_field(string name, int got, int want);
      if (got != want)
        report($sformatf("result %0d %s got %0h want %0h", checked, name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report("result with no request waiting for one");
        return;
      end
      want = pending_results.pop_front();
      checked++;
      compare_field("res_kind", got.res_kind, want.res_kind);
      compare_field("payload_byte", got.payload_byte, want.payload_byte);
      compare_field("byte_index", got.byte_index, want.byte_index);
      compare_field("status", got.status, want.status);
      compare_field("ack_request", got.ack_request, want.ack_request);
      compare_field("ack_value", got.ack_value, want.ack_value);
      compare_field("break_active", got.break_active, want.break_active);
      compare_field("body_length", got.body_length, want.body_length);
      if (want.res_kind == KIND_PAYLOAD) begin
        payloads++;
      end else begin
        ends++;
        status_seen[want.status]++;
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic func;
  logic [7:0] rx_byte;
  logic more_pending;
  logic out_valid;
  logic out_ready;
  logic res_kind;
  logic [7:0] payload_byte;
  logic [7:0] byte_index;
  logic [1:0] status;
  logic [1:0] ack_request;
  logic [7:0] ack_value;
  logic break_active;
  logic [7:0] body_length;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  frame_board board;
  cfg_t cur_cfg;
  int send_idle;
  int recv_idle;
  int tick_pct;
  int items_sent;
  int settings_used;
  int hold_left;
  bit hold_arm;
  int cycles;

  escaped_frame_receiver dut (.*);

  always #10 clk = ~clk;

  task send_request(input logic f, input logic [7:0] b, input logic m);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    rx_byte <= b;
    more_pending <= m;
    do @(posedge clk); while (!in_ready);
    board.note_request(f, b, m);
    items_sent++;
  endtask

  task send_byte(input logic [7:0] b, input logic m);
    if ($urandom_range(999) < tick_pct) send_request(FUNC_TICK, 8'($urandom), 1'($urandom));
    send_request(FUNC_BYTE, b, m);
  endtask

  task send_seq(input logic [7:0] seq[$], input bit stale_last);
    for (int i = 0; i < seq.size(); i++)
      send_request(FUNC_BYTE, seq[i], stale_last && i == seq.size() - 1);
  endtask

  task put_escaped(input logic [7:0] b, input logic m);
    if (b == cur_cfg.escape_byte || b == cur_cfg.open_byte || $urandom_range(9) == 0) begin
      send_byte(cur_cfg.escape_byte, 1'($urandom));
      send_byte(b ^ ESC_XOR, m);
    end else begin
      send_byte(b, m);
    end
  endtask

  // keep < len stops the frame early, leaving the parser mid body
  task send_frame(input logic [7:0] t, input int len, input bit good_sum, input bit stale,
                  input int last_body, input int keep);
    logic [7:0] total;
    logic [7:0] b;
    send_byte(cur_cfg.open_byte, 1'($urandom));
    put_escaped(8'(len), 1'($urandom));
    put_escaped(t, 1'($urandom));
    total = t;
    for (int i = 0; i < len; i++) begin
      if (i == keep) return;
      b = (i == len - 1 && last_body >= 0) ? 8'(last_body) : 8'($urandom);
      total = total + b;
      put_escaped(b, 1'($urandom));
    end
    b = SUM_GOOD - total;
    if (!good_sum) b = b + 8'($urandom_range(1, 255));
    put_escaped(b, stale);
  endtask

  function logic [7:0] pick_type();
    int r;
    r = $urandom_range(99);
    if (r < 60) return cur_cfg.data_type;
    if (r < 85) return cur_cfg.ack_type;
    if (r < 93) return cur_cfg.expected_type;
    return 8'($urandom);
  endfunction

  task random_step();
    int r;
    int n;
    int len;
    logic [7:0] t;
    r = $urandom_range(99);
    if (r < 6) begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom), 1'($urandom));
    end else if (r < 10) begin
      len = $urandom_range(2, 10);
      send_frame(pick_type(), len, 1'b1, 1'b0, -1, $urandom_range(0, len - 1));
    end else if (r < 14) begin
      n = (cur_cfg.timeout_ticks <= 40) ? $urandom_range(1, cur_cfg.timeout_ticks)
                                        : $urandom_range(1, 5);
      repeat (n) send_request(FUNC_TICK, 8'($urandom), 1'($urandom));
    end else begin
      t = pick_type();
      len = ($urandom_range(99) < 2) ? $urandom_range(200, 255) : $urandom_range(0, 10);
      send_frame(t, len, $urandom_range(99) < 85, $urandom_range(99) < 10,
                 (t == cur_cfg.ack_type && $urandom_range(1) == 1) ? int'(cur_cfg.break_code) : -1,
                 len);
    end
  endtask

  task set_config(input cfg_t c);
    logic [2:0] idxs[7];
    logic [15:0] vals[7];
    idxs = '{REG_OPEN_BYTE, REG_ESCAPE_BYTE, REG_EXPECTED_TYPE, REG_DATA_TYPE,
             REG_ACK_TYPE, REG_BREAK_CODE, REG_TIMEOUT_TICKS};
    vals = '{{8'h00, c.open_byte}, {8'h00, c.escape_byte}, {8'h00, c.expected_type},
             {8'h00, c.data_type}, {8'h00, c.ack_type}, {8'h00, c.break_code}, c.timeout_ticks};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data <= vals[i];
      board.write_reg(idxs[i], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_cfg = c;
    settings_used++;
  endtask

  // drop valid, drain every expected result, then cover requests still in flight
  task settle();
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function cfg_t random_cfg();
    cfg_t c;
    int r;
    c.open_byte = 8'($urandom);
    c.escape_byte = 8'($urandom);
    c.data_type = 8'($urandom);
    c.ack_type = c.data_type ^ 8'($urandom_range(1, 255));
    r = $urandom_range(99);
    c.expected_type = (r < 50) ? c.data_type : (r < 85) ? c.ack_type : 8'($urandom);
    c.break_code = 8'($urandom);
    c.timeout_ticks = ($urandom_range(99) < 80) ? 16'($urandom_range(1, 25))
                                                : 16'($urandom_range(26, 65535));
    return c;
  endfunction

  initial begin
    result_t got;
    out_ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = {res_kind, payload_byte, byte_index, status, ack_request, ack_value,
               break_active, body_length};
        board.check_result(got);
      end
      if (hold_arm) begin
        hold_arm = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top: timed out after %0d cycles", cycles);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    cfg_t c;
    int target;
    rst <= 1'b1;
    in_valid <= 1'b0;
    func <= FUNC_BYTE;
    rx_byte <= 8'h00;
    more_pending <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_OPEN_BYTE;
    cfg_data <= 16'h0000;
    send_idle = 38;
    recv_idle = 79;
    tick_pct = 0;
    items_sent = 0;
    settings_used = 0;
    hold_arm = 1'b0;
    board = new();
    cur_cfg = board.regs;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // data frame with zero, escaped and all-ones body bytes
    send_seq('{8'h7E, 8'h03, 8'h01, 8'h00, 8'h7D, 8'h5D, 8'hFF, 8'h82}, 1'b0);
    // zero length with bad checksum
    send_seq('{8'h7E, 8'h00, 8'h01, 8'h00}, 1'b0);
    // more bytes waiting on the checksum drops the frame
    send_seq('{8'h7E, 8'h01, 8'h01, 8'hAA, 8'h54}, 1'b1);
    settle();
    c = cur_cfg;
    c.expected_type = RST_ACK_TYPE;
    c.timeout_ticks = 16'd2;
    set_config(c);
    // ack carrying the break code, then an escape cut off by a timeout
    send_seq('{8'h7E, 8'h01, 8'h02, 8'h03, 8'hFA}, 1'b0);
    send_seq('{8'h7E, 8'h7D}, 1'b0);
    send_request(FUNC_TICK, 8'h00, 1'b0);
    send_request(FUNC_TICK, 8'hFF, 1'b1);
    settle();

    for (int p = 0; p < 9; p++) begin
      case (p / 3)
        0: begin
          send_idle = 38;
          recv_idle = 79;
        end
        1: begin
          send_idle = 79;
          recv_idle = 38;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      case (p)
        0: c = '{RST_OPEN_BYTE, RST_ESCAPE_BYTE, RST_EXPECTED_TYPE, RST_DATA_TYPE,
                 RST_ACK_TYPE, RST_BREAK_CODE, RST_TIMEOUT_TICKS};
        1: c = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 16'd1};
        2: c = '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 16'hFFFF};
        3: c = '{8'h7E, 8'h7D, 8'h20, 8'h10, 8'h20, 8'($urandom), 16'd20};
        default: c = random_cfg();
      endcase
      set_config(c);
      tick_pct = 15;
      if (p == 6) hold_arm = 1'b1;
      target = items_sent + 220;
      while (items_sent < target) random_step();
      settle();
    end
    repeat (12) @(posedge clk);

    $display("tb_top: %0d requests over %0d register settings, %0d results checked",
             items_sent, settings_used, board.checked);
    $display("tb_top: %0d payload bytes, read ends ok %0d failed %0d timeout %0d break %0d",
             board.payloads, board.status_seen[ST_OK], board.status_seen[ST_FAILED],
             board.status_seen[ST_TIMEOUT], board.status_seen[ST_BREAK]);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/efr_pkg.sv
rtl/efr_core.sv
rtl/escaped_frame_receiver.sv
verif/tb_top.sv
